// ----- hw/rtl/hetu_pkg.sv -----
// ----------------------------------------------------------------------------
// hetu_pkg - shared types and constants of the HTML entity decoder
// Outcome record passed from parser to encoder, character codes, the named
// entity table and the UTF-8 framing constants.
// ----------------------------------------------------------------------------
package hetu_pkg;

  // Text characters the parser reacts to
  localparam logic [7:0] CH_AMP  = 8'h26;  // '&'
  localparam logic [7:0] CH_HASH = 8'h23;  // '#'
  localparam logic [7:0] CH_SEMI = 8'h3B;  // ';'
  localparam logic [7:0] CH_XLO  = 8'h78;  // 'x'
  localparam logic [7:0] CH_XUP  = 8'h58;  // 'X'
  localparam logic [7:0] CH_D0   = 8'h30;  // '0'
  localparam logic [7:0] CH_D9   = 8'h39;  // '9'
  localparam logic [7:0] CH_ALO  = 8'h61;  // 'a'
  localparam logic [7:0] CH_FLO  = 8'h66;  // 'f'
  localparam logic [7:0] CH_AUP  = 8'h41;  // 'A'
  localparam logic [7:0] CH_FUP  = 8'h46;  // 'F'

  // Code point limits and UTF-8 class bounds
  localparam logic [31:0] CP_MAX   = 32'h0010_FFFF;
  localparam logic [20:0] CP_LIM1  = 21'h00_007F;
  localparam logic [20:0] CP_LIM2  = 21'h00_07FF;
  localparam logic [20:0] CP_LIM3  = 21'h00_FFFF;
  localparam logic [7:0]  LEAD2    = 8'hC0;
  localparam logic [7:0]  LEAD3    = 8'hE0;
  localparam logic [7:0]  LEAD4    = 8'hF0;
  localparam logic [7:0]  CONT     = 8'h80;
  localparam logic [4:0]  MASK2    = 5'h1F;
  localparam logic [3:0]  MASK3    = 4'h0F;
  localparam logic [2:0]  MASK4    = 3'h07;
  localparam logic [5:0]  MASK_C   = 6'h3F;

  // One outcome of an attempt: code point to encode, or a failure
  typedef struct packed {
    logic        ok;
    logic [20:0] cp;
    logic [3:0]  consumed;
  } outcome_t;

  // Named entity table, strings right-aligned
  localparam int NAME_COUNT = 31;

  localparam logic [63:0] NAME_STR [NAME_COUNT] = '{
    "amp", "lt", "gt", "quot", "apos", "nbsp", "copy", "reg",
    "trade", "mdash", "ndash", "bull", "hellip", "prime", "Prime", "lsquo",
    "rsquo", "ldquo", "rdquo", "laquo", "raquo", "times", "divide", "plusmn",
    "deg", "sect", "para", "euro", "pound", "yen", "cent"
  };

  localparam logic [2:0] NAME_CHARS [NAME_COUNT] = '{
    3'd3, 3'd2, 3'd2, 3'd4, 3'd4, 3'd4, 3'd4, 3'd3,
    3'd5, 3'd5, 3'd5, 3'd4, 3'd6, 3'd5, 3'd5, 3'd5,
    3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd6, 3'd6,
    3'd3, 3'd4, 3'd4, 3'd4, 3'd5, 3'd3, 3'd4
  };

  localparam logic [20:0] NAME_CP [NAME_COUNT] = '{
    21'h26,   21'h3C,   21'h3E,   21'h22,   21'h27,   21'hA0,   21'hA9,   21'hAE,
    21'h2122, 21'h2014, 21'h2013, 21'h2022, 21'h2026, 21'h2032, 21'h2033, 21'h2018,
    21'h2019, 21'h201C, 21'h201D, 21'hAB,   21'hBB,   21'hD7,   21'hF7,   21'hB1,
    21'hB0,   21'hA7,   21'hB6,   21'h20AC, 21'hA3,   21'hA5,   21'hA2
  };

  // Character j (from the left) of table entry i; only valid for j below the length
  function automatic logic [7:0] name_chr(input int unsigned i, input logic [2:0] j);
    logic [2:0] sh;
    sh = NAME_CHARS[i] - 3'd1 - j;
    return NAME_STR[i][{sh, 3'b000} +: 8];
  endfunction

endpackage

// ----- hw/rtl/hetu_front.sv -----
// ----------------------------------------------------------------------------
// hetu_front - entity parser
// Takes one text byte per cycle while the outcome queue is not full, tracks the
// open attempt and pushes one outcome record per attempt into the outcome queue.
// ----------------------------------------------------------------------------
module hetu_front #(
  parameter int MAX_SEMI_INDEX = 12
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [7:0]        in_byte,
  input  logic              start_req,
  input  logic              at_end,
  input  logic              byte_valid,
  output logic              byte_stall,
  input  logic              q_full,
  output logic              push,
  output hetu_pkg::outcome_t rec
);
  import hetu_pkg::*;

  localparam logic [3:0] MAX_POS = 4'(MAX_SEMI_INDEX);

  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_AMP  = 3'd1;
  localparam logic [2:0] MODE_HASH = 3'd2;
  localparam logic [2:0] MODE_DEC  = 3'd3;
  localparam logic [2:0] MODE_HEX  = 3'd4;
  localparam logic [2:0] MODE_NAME = 3'd5;
  localparam logic [2:0] MODE_BAD  = 3'd6;

  logic [2:0]            mode, mode_next;
  logic [3:0]            pos, pos_next;
  logic [31:0]           code, code_next;
  logic [NAME_COUNT-1:0] match, match_next;

  logic                  accept;
  logic                  is_dec, is_hex_lo, is_hex_up;
  logic [3:0]            digit;
  logic [31:0]           code_dec, code_hex;
  logic [3:0]            name_idx;
  logic [NAME_COUNT-1:0] chr_hit;
  logic [3:0]            nlen;
  logic                  name_hit;
  logic [20:0]           name_cp;
  logic [4:0]            cons_sum;
  logic [3:0]            cons;
  outcome_t              fin_rec;
  outcome_t              fail0_rec;

  // Queue full holds the byte stream
  assign byte_stall = q_full;
  assign accept     = byte_valid & ~q_full;

  // Digit classes; low nibble is the value for 0-9, plus 9 for letters
  assign is_dec    = (in_byte >= CH_D0)  && (in_byte <= CH_D9);
  assign is_hex_lo = (in_byte >= CH_ALO) && (in_byte <= CH_FLO);
  assign is_hex_up = (in_byte >= CH_AUP) && (in_byte <= CH_FUP);
  assign digit     = is_dec ? in_byte[3:0] : in_byte[3:0] + 4'd9;

  // Value update, modulo 2^32
  assign code_dec = {code[28:0], 3'b000} + {code[30:0], 1'b0} + {28'd0, in_byte[3:0]};
  assign code_hex = {code[27:0], digit};

  // Running name match: one bit per table entry
  assign name_idx = (mode == MODE_AMP) ? 4'd0 : pos - 4'd1;

  always_comb begin
    for (int i = 0; i < NAME_COUNT; i++) begin
      chr_hit[i] = (name_idx < 4'(NAME_CHARS[i])) &&
                   (name_chr(i, name_idx[2:0]) == in_byte);
    end
  end

  // Name lookup at the semicolon
  assign nlen = pos - 4'd1;

  always_comb begin
    name_hit = 1'b0;
    name_cp  = '0;
    for (int i = 0; i < NAME_COUNT; i++) begin
      if (match[i] && (4'(NAME_CHARS[i]) == nlen)) begin
        name_hit = 1'b1;
        name_cp  = name_cp | NAME_CP[i];
      end
    end
  end

  // Consumed count, saturated at 15
  assign cons_sum = {1'b0, pos} + 5'd1;
  assign cons     = (cons_sum > 5'd15) ? 4'hF : cons_sum[3:0];

  // Outcome when the semicolon arrives
  always_comb begin
    fin_rec.consumed = cons;
    fin_rec.ok       = 1'b0;
    fin_rec.cp       = '0;
    if ((mode == MODE_DEC) || (mode == MODE_HEX)) begin
      if ((code != '0) && (code <= CP_MAX)) begin
        fin_rec.ok = 1'b1;
        fin_rec.cp = code[20:0];
      end
    end else if (mode == MODE_NAME) begin
      if (name_hit) begin
        fin_rec.ok = 1'b1;
        fin_rec.cp = name_cp;
      end
    end
  end

  assign fail0_rec = '{ok: 1'b0, cp: 21'd0, consumed: 4'd0};

  // Parser step per accepted byte
  always_comb begin
    mode_next  = mode;
    pos_next   = pos;
    code_next  = code;
    match_next = match;
    push       = 1'b0;
    rec        = fin_rec;
    if (accept) begin
      if (start_req) begin
        if ((in_byte != CH_AMP) || at_end) begin
          mode_next = MODE_IDLE;
          push      = 1'b1;
          rec       = fail0_rec;
        end else begin
          mode_next = MODE_AMP;
          pos_next  = 4'd1;
          code_next = '0;
        end
      end else if (mode != MODE_IDLE) begin
        if (in_byte == CH_SEMI) begin
          mode_next = MODE_IDLE;
          push      = 1'b1;
          rec       = fin_rec;
        end else if ((pos >= MAX_POS) || at_end) begin
          mode_next = MODE_IDLE;
          push      = 1'b1;
          rec       = fail0_rec;
        end else begin
          pos_next = pos + 4'd1;
          unique case (mode)
            MODE_AMP: begin
              if (in_byte == CH_HASH) begin
                mode_next = MODE_HASH;
              end else begin
                mode_next  = MODE_NAME;
                match_next = chr_hit;
              end
            end
            MODE_HASH: begin
              if ((in_byte == CH_XLO) || (in_byte == CH_XUP)) begin
                mode_next = MODE_HEX;
              end else if (is_dec) begin
                mode_next = MODE_DEC;
                code_next = {28'd0, in_byte[3:0]};
              end else begin
                mode_next = MODE_BAD;
              end
            end
            MODE_DEC: begin
              if (is_dec) code_next = code_dec;
              else        mode_next = MODE_BAD;
            end
            MODE_HEX: begin
              if (is_dec || is_hex_lo || is_hex_up) code_next = code_hex;
              else                                  mode_next = MODE_BAD;
            end
            MODE_NAME: begin
              match_next = match & chr_hit;
            end
            default: begin
            end
          endcase
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= MODE_IDLE;
      pos  <= '0;
      code <= '0;
    end else begin
      mode <= mode_next;
      pos  <= pos_next;
      code <= code_next;
    end
  end

  // Match vector is payload, written before it is read
  always_ff @(posedge clk) begin
    match <= match_next;
  end

endmodule

// ----- hw/rtl/hetu_fifo.sv -----
// ----------------------------------------------------------------------------
// hetu_fifo - outcome queue
// Short register queue between parser and encoder.
// ----------------------------------------------------------------------------
module hetu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  hetu_pkg::outcome_t wr_data,
  output logic               full,
  input  logic               pop,
  output logic               empty,
  output hetu_pkg::outcome_t rd_data
);
  import hetu_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  outcome_t        mem [DEPTH];
  logic [PW-1:0]   wr_ptr, rd_ptr;
  logic [CW-1:0]   count;
  logic            do_push, do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push & ~full;
  assign do_pop  = pop & ~empty;
  assign rd_data = mem[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= wr_data;
  end

endmodule

// ----- hw/rtl/hetu_back.sv -----
// ----------------------------------------------------------------------------
// hetu_back - UTF-8 encoder
// Turns the outcome at the queue head into one to four result transactions
// through a registered output stage.
// ----------------------------------------------------------------------------
module hetu_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  hetu_pkg::outcome_t head,
  output logic               pop,
  output logic [7:0]         out_byte,
  output logic               ok,
  output logic [3:0]         consumed,
  output logic               is_last,
  output logic               result_valid,
  input  logic               result_stall
);
  import hetu_pkg::*;

  logic [1:0]  idx;
  logic [1:0]  nm1;
  logic [1:0]  rem;
  logic [23:0] cpx;
  logic [7:0]  lead;
  logic [7:0]  enc;
  logic        load;
  logic        last_now;

  // Byte count minus one; a failure is a single zero byte
  always_comb begin
    if (!head.ok)                nm1 = 2'd0;
    else if (head.cp <= CP_LIM1) nm1 = 2'd0;
    else if (head.cp <= CP_LIM2) nm1 = 2'd1;
    else if (head.cp <= CP_LIM3) nm1 = 2'd2;
    else                         nm1 = 2'd3;
  end

  // Lead byte per length
  always_comb begin
    case (nm1)
      2'd0:    lead = head.ok ? head.cp[7:0] : 8'h00;
      2'd1:    lead = LEAD2 | {3'b000, head.cp[10:6] & MASK2};
      2'd2:    lead = LEAD3 | {4'h0, head.cp[15:12] & MASK3};
      default: lead = LEAD4 | {5'b00000, head.cp[20:18] & MASK4};
    endcase
  end

  // Continuation byte: six bits counted from the end
  assign cpx      = {3'b000, head.cp};
  assign rem      = nm1 - idx;
  assign enc      = (idx == 2'd0) ? lead
                                  : (CONT | {2'b00, cpx[{rem, 2'b00} + {1'b0, rem, 1'b0} +: 6]
                                              & MASK_C});
  assign last_now = (idx == nm1);

  assign load = ~result_valid | ~result_stall;
  assign pop  = load & ~q_empty & last_now;

  // Output stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      idx          <= '0;
    end else if (load) begin
      result_valid <= ~q_empty;
      if (!q_empty) idx <= last_now ? 2'd0 : idx + 2'd1;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_byte <= enc;
      ok       <= head.ok;
      consumed <= head.consumed;
      is_last  <= last_now;
    end
  end

endmodule

// ----- hw/rtl/html_entity_to_utf8.sv -----
// ----------------------------------------------------------------------------
// html_entity_to_utf8 - streaming HTML character reference decoder
// Parses one entity candidate per attempt and emits its UTF-8 bytes, or a
// single failure result.
//
//   channel   valid          stall          payload
//   text in   byte_valid     byte_stall     in_byte, start_req, at_end
//   result    result_valid   result_stall   out_byte, ok, consumed, is_last
//
// One text byte is taken per cycle; the parser answers in the cycle it sees
// the byte and queues one outcome per attempt.
// The encoder gives one result byte per cycle when not stalled, one to four per outcome, so
// text bytes stall only when the outcome queue (QUEUE_DEPTH entries) is full.
// The closing byte's outcome passes through the outcome queue and the registered output stage.
// Synchronous reset clears the parser, queue and output stage; no clearing pass.
// ----------------------------------------------------------------------------
module html_entity_to_utf8 #(
  parameter int MAX_SEMI_INDEX = 12,
  parameter int QUEUE_DEPTH    = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic [7:0] in_byte,
  input  logic       start_req,
  input  logic       at_end,
  input  logic       byte_valid,
  output logic       byte_stall,
  output logic [7:0] out_byte,
  output logic       ok,
  output logic [3:0] consumed,
  output logic       is_last,
  output logic       result_valid,
  input  logic       result_stall
);
  import hetu_pkg::*;

  logic     q_full, q_empty, q_push, q_pop;
  outcome_t q_wr, q_head;

  // Parser
  hetu_front #(.MAX_SEMI_INDEX(MAX_SEMI_INDEX)) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_byte    (in_byte),
    .start_req  (start_req),
    .at_end     (at_end),
    .byte_valid (byte_valid),
    .byte_stall (byte_stall),
    .q_full     (q_full),
    .push       (q_push),
    .rec        (q_wr)
  );

  // Outcome queue
  hetu_fifo #(.DEPTH(QUEUE_DEPTH)) u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .wr_data (q_wr),
    .full    (q_full),
    .pop     (q_pop),
    .empty   (q_empty),
    .rd_data (q_head)
  );

  // Encoder
  hetu_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .head         (q_head),
    .pop          (q_pop),
    .out_byte     (out_byte),
    .ok           (ok),
    .consumed     (consumed),
    .is_last      (is_last),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

  // A failure is one zero byte closing its attempt
  a_fail_single: assert property (@(posedge clk) disable iff (rst)
    result_valid && !ok |-> is_last && (out_byte == 8'h00))
    else $error("failure result not a single zero byte");

  // The shortest decodable reference spans four bytes
  a_ok_consumed: assert property (@(posedge clk) disable iff (rst)
    result_valid && ok |-> consumed >= 4'd4)
    else $error("decoded byte with too short a reference");

  // Bytes of one code point follow without a gap
  a_burst_dense: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_stall && !is_last |=> result_valid)
    else $error("gap inside a multi-byte result");

  // Stall on text only while the queue is full
  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    byte_stall |-> !q_pop || q_full)
    else $error("text stalled without a full queue");

endmodule
